// ===== hdl/attack_release_level_smoother_unit_assert.svh =====
// assertion macros shared by the level smoother rtl
`ifndef ATTACK_RELEASE_LEVEL_SMOOTHER_UNIT_ASSERT_SVH
`define ATTACK_RELEASE_LEVEL_SMOOTHER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ARLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ARLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/arls_pkg.sv =====
// shared types, register codes and exponential tables of the level smoother
`default_nettype none

package arls_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_EXP,
    ST_ALPHA,
    ST_SCALE,
    ST_APPLY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  localparam logic [1:0] REG_SILENCE_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ATTACK_TAU        = 2'd1;
  localparam logic [1:0] REG_RELEASE_TAU       = 2'd2;

  localparam logic [15:0] SILENCE_THRESHOLD_RST = 16'd1311;
  localparam logic [15:0] ATTACK_TAU_RST        = 16'd40;
  localparam logic [15:0] RELEASE_TAU_RST       = 16'd250;

  // exp(-2^-j) in q0.32: alternating taylor series in q2.62, truncated terms
  function automatic logic [31:0] exp_frac_entry(input int unsigned j);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] t;
    logic [63:0] sum;
    pos = 64'd1 << 62;
    neg = '0;
    t   = pos;
    t = (t >> j) / 64'd1;   neg = neg + t;
    t = (t >> j) / 64'd2;   pos = pos + t;
    t = (t >> j) / 64'd3;   neg = neg + t;
    t = (t >> j) / 64'd4;   pos = pos + t;
    t = (t >> j) / 64'd5;   neg = neg + t;
    t = (t >> j) / 64'd6;   pos = pos + t;
    t = (t >> j) / 64'd7;   neg = neg + t;
    t = (t >> j) / 64'd8;   pos = pos + t;
    t = (t >> j) / 64'd9;   neg = neg + t;
    t = (t >> j) / 64'd10;  pos = pos + t;
    t = (t >> j) / 64'd11;  neg = neg + t;
    t = (t >> j) / 64'd12;  pos = pos + t;
    t = (t >> j) / 64'd13;  neg = neg + t;
    t = (t >> j) / 64'd14;  pos = pos + t;
    t = (t >> j) / 64'd15;  neg = neg + t;
    t = (t >> j) / 64'd16;  pos = pos + t;
    t = (t >> j) / 64'd17;  neg = neg + t;
    t = (t >> j) / 64'd18;  pos = pos + t;
    t = (t >> j) / 64'd19;  neg = neg + t;
    t = (t >> j) / 64'd20;  pos = pos + t;
    t = (t >> j) / 64'd21;  neg = neg + t;
    t = (t >> j) / 64'd22;  pos = pos + t;
    t = (t >> j) / 64'd23;  neg = neg + t;
    t = (t >> j) / 64'd24;  pos = pos + t;
    t = (t >> j) / 64'd25;  neg = neg + t;
    t = (t >> j) / 64'd26;  pos = pos + t;
    t = (t >> j) / 64'd27;  neg = neg + t;
    t = (t >> j) / 64'd28;  pos = pos + t;
    t = (t >> j) / 64'd29;  neg = neg + t;
    t = (t >> j) / 64'd30;  pos = pos + t;
    t = (t >> j) / 64'd31;  neg = neg + t;
    t = (t >> j) / 64'd32;  pos = pos + t;
    t = (t >> j) / 64'd33;  neg = neg + t;
    t = (t >> j) / 64'd34;  pos = pos + t;
    t = (t >> j) / 64'd35;  neg = neg + t;
    t = (t >> j) / 64'd36;  pos = pos + t;
    t = (t >> j) / 64'd37;  neg = neg + t;
    t = (t >> j) / 64'd38;  pos = pos + t;
    t = (t >> j) / 64'd39;  neg = neg + t;
    sum = (pos - neg) + (64'd1 << 29);
    return 32'(sum >> 30);
  endfunction

  // exp(-2^m) in q0.32 by repeated rounded squaring of exp(-1)
  function automatic logic [31:0] exp_int_entry(input int unsigned m);
    logic [63:0] v;
    v = 64'(exp_frac_entry(0));
    for (int unsigned i = 1; i <= m; i++) begin
      v = (v * v + (64'd1 << 31)) >> 32;
    end
    return 32'(v);
  endfunction

  localparam logic [31:0] EXP_FRAC_TAB [17] = '{
    exp_frac_entry(0),  exp_frac_entry(1),  exp_frac_entry(2),  exp_frac_entry(3),
    exp_frac_entry(4),  exp_frac_entry(5),  exp_frac_entry(6),  exp_frac_entry(7),
    exp_frac_entry(8),  exp_frac_entry(9),  exp_frac_entry(10), exp_frac_entry(11),
    exp_frac_entry(12), exp_frac_entry(13), exp_frac_entry(14), exp_frac_entry(15),
    exp_frac_entry(16)
  };

  localparam logic [31:0] EXP_INT_TAB [5] = '{
    exp_int_entry(0), exp_int_entry(1), exp_int_entry(2), exp_int_entry(3),
    exp_int_entry(4)
  };

endpackage

`default_nettype wire

// ===== hdl/arls_ratio_div.sv =====
// bit-serial divider for elapsed/tau in fixed point, saturated at 16.0
`default_nettype none

module arls_ratio_div #(
  parameter int RATIO_FRAC_BITS = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [15:0]                elapsed_ms,
  input  wire logic [15:0]                tau_ms,
  output arls_pkg::div_status_t           status,
  output logic [RATIO_FRAC_BITS+4:0]      ratio
);
  import arls_pkg::*;

  localparam int QW = RATIO_FRAC_BITS + 5;
  localparam int CW = $clog2(QW + 1);
  localparam logic [QW-1:0] RatioMax = {1'b1, {(QW-1){1'b0}}};

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [15:0]   rem;
  logic [15:0]   tau_r;
  logic [QW-1:0] shreg;
  logic          sat;
  logic [16:0]   trial;
  logic          fits;

  // dividend bits shift in from shreg's top, quotient bits in at its bottom
  assign trial = {rem, shreg[QW-1]};
  assign fits  = trial >= {1'b0, tau_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(QW);
        rem   <= {5'b0, elapsed_ms[15:5]};
        shreg <= {elapsed_ms[4:0], {RATIO_FRAC_BITS{1'b0}}};
        tau_r <= tau_ms;
        // quotient needs more bits than kept: saturate
        sat   <= {5'b0, elapsed_ms[15:5]} >= tau_ms;
      end else if (busy) begin
        rem   <= fits ? 16'(trial - {1'b0, tau_r}) : trial[15:0];
        shreg <= {shreg[QW-2:0], fits};
        cnt   <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ratio       = (sat || shreg > RatioMax) ? RatioMax : shreg;
  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

// ===== hdl/attack_release_level_smoother_unit.sv =====
// attack/release level smoother: sequencer, shared multiplier and registers
// flow: an input is taken only in idle, so each item finishes before the next one is accepted;
//   the result waits in ST_OUT until the output register is free
// the ratio divider yields one quotient bit per cycle and the exp product
//   handles one ratio bit per cycle
// reset: synchronous; held level clears to zero, registers take their defaults
`default_nettype none
`include "attack_release_level_smoother_unit_assert.svh"

module attack_release_level_smoother_unit #(
  parameter int LEVEL_BITS      = 16,
  parameter int RATIO_FRAC_BITS = 12
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // target_level [LEVEL_BITS-1:0], elapsed_ms [LEVEL_BITS+15:LEVEL_BITS], zero pad
  input  wire logic [((LEVEL_BITS+16+7)/8)*8-1:0]     s_tdata,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // smoothed_level [LEVEL_BITS-1:0], zero pad
  output logic [((LEVEL_BITS+7)/8)*8-1:0]             m_tdata,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [3:0]                             paddr,
  input  wire logic [31:0]                            pwdata,
  output logic [31:0]                                 prdata,
  output logic                                        pready
);
  import arls_pkg::*;

  localparam int L  = LEVEL_BITS;
  localparam int OW = ((LEVEL_BITS + 7) / 8) * 8;
  localparam int QW = RATIO_FRAC_BITS + 5;
  localparam int BW = $clog2(QW);
  localparam logic [BW-1:0] LastBit   = BW'(QW - 1);
  localparam logic [L:0]    LevelOne  = {1'b1, {L{1'b0}}};
  localparam logic [32:0]   ExpRound  = 33'(1) << (31 - LEVEL_BITS);
  localparam logic [63:0]   MagRound  = 64'(1) << (LEVEL_BITS - 1);
  localparam logic [L-1:0]  SnapLevel = L'(((2 ** LEVEL_BITS) + 500) / 1000);

  state_t state;
  state_t state_next;

  logic [15:0]   silence_threshold;
  logic [15:0]   attack_tau_ms;
  logic [15:0]   release_tau_ms;
  logic [L-1:0]  held_level;
  logic [L-1:0]  wanted;
  logic [15:0]   elapsed;
  logic          rising;
  logic [L-1:0]  diff;
  logic [QW-1:0] ratio;
  logic [31:0]   acc;
  logic          acc_one;
  logic [BW-1:0] bit_idx;
  logic [L:0]    alpha;
  logic [L-1:0]  mag;
  logic [L-1:0]  res;

  logic          cfg_write;
  logic          div_start;
  logic          out_load;
  div_status_t   div_st;
  logic [QW-1:0] div_ratio;
  logic [L-1:0]  in_target;
  logic [15:0]   in_elapsed;
  logic          rising_w;
  logic [15:0]   tau_sel;
  logic [15:0]   tau_eff;
  logic [4:0]    frac_idx;
  logic [2:0]    int_idx;
  logic [31:0]   entry;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   mul_p;
  logic [32:0]   e_sum;
  logic [L:0]    e_lvl;
  logic [L-1:0]  lvl_moved;

  assign in_target  = s_tdata[L-1:0];
  assign in_elapsed = s_tdata[L+15:L];

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_threshold <= SILENCE_THRESHOLD_RST;
      attack_tau_ms     <= ATTACK_TAU_RST;
      release_tau_ms    <= RELEASE_TAU_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_SILENCE_THRESHOLD: silence_threshold <= pwdata[15:0];
        REG_ATTACK_TAU:        attack_tau_ms     <= pwdata[15:0];
        REG_RELEASE_TAU:       release_tau_ms    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SILENCE_THRESHOLD: prdata = 32'(silence_threshold);
      REG_ATTACK_TAU:        prdata = 32'(attack_tau_ms);
      REG_RELEASE_TAU:       prdata = 32'(release_tau_ms);
      default:               prdata = '0;
    endcase
  end

  // direction and time constant, zero tau acts as one ms
  assign rising_w = wanted > held_level;
  assign tau_sel  = rising_w ? attack_tau_ms : release_tau_ms;
  assign tau_eff  = (tau_sel == 16'd0) ? 16'd1 : tau_sel;

  arls_ratio_div #(
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .elapsed_ms(elapsed),
    .tau_ms    (tau_eff),
    .status    (div_st),
    .ratio     (div_ratio)
  );

  // table entry for ratio bit: fractional bits use exp(-2^-j), integer bits exp(-2^m)
  assign frac_idx = 5'(RATIO_FRAC_BITS - int'(bit_idx));
  assign int_idx  = 3'(int'(bit_idx) - RATIO_FRAC_BITS);
  assign entry    = (int'(bit_idx) < RATIO_FRAC_BITS) ? EXP_FRAC_TAB[frac_idx]
                                                      : EXP_INT_TAB[int_idx];

  // shared multiplier: exponential product, then level step
  assign mul_a = (state == ST_EXP) ? acc   : 32'(diff);
  assign mul_b = (state == ST_EXP) ? entry : 32'(alpha);
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign e_sum     = {1'b0, acc} + ExpRound;
  assign e_lvl     = (L+1)'(e_sum >> (32 - LEVEL_BITS));
  assign lvl_moved = rising ? L'(held_level + mag) : L'(held_level - mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_PREP;
      end
      ST_PREP: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_st.done) state_next = ST_EXP;
      end
      ST_EXP: begin
        if (bit_idx == LastBit) state_next = ST_ALPHA;
      end
      ST_ALPHA: state_next = ST_SCALE;
      ST_SCALE: state_next = ST_APPLY;
      ST_APPLY: state_next = ST_OUT;
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_level <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) begin
        held_level <= res;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= OW'(res);
    unique case (state)
      ST_IDLE: begin
        // silent targets count as zero
        wanted  <= (32'(in_target) < 32'(silence_threshold)) ? '0 : in_target;
        elapsed <= in_elapsed;
      end
      ST_PREP: begin
        rising <= rising_w;
        diff   <= rising_w ? L'(wanted - held_level) : L'(held_level - wanted);
      end
      ST_DIV: begin
        ratio   <= div_ratio;
        acc_one <= 1'b1;
        bit_idx <= '0;
      end
      ST_EXP: begin
        if (ratio[bit_idx]) begin
          // 1.0 times an entry is the entry itself
          acc     <= acc_one ? entry : 32'((mul_p + 64'h8000_0000) >> 32);
          acc_one <= 1'b0;
        end
        bit_idx <= BW'(bit_idx + 1'b1);
      end
      ST_ALPHA: alpha <= acc_one ? '0 : LevelOne - e_lvl;
      ST_SCALE: mag   <= L'((mul_p + MagRound) >> LEVEL_BITS);
      ST_APPLY: res   <= (lvl_moved < SnapLevel) ? '0 : lvl_moved;
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  `ARLS_ASSERT_NEXT(held_only_on_load, state != ST_OUT, $stable(held_level),
                    "held level changed outside result load")
  `ARLS_ASSERT_NOW(div_quiet_in_idle, state == ST_IDLE, !div_st.busy,
                   "divider busy while sequencer idle")
  `ARLS_ASSERT_NOW(div_done_in_div, div_st.done, state == ST_DIV,
                   "divider finished outside divide phase")
  `ARLS_ASSERT_NOW(result_in_range, state == ST_OUT,
                   (res == '0) || (rising ? (res >= held_level && res <= wanted)
                                          : (res <= held_level && res >= wanted)),
                   "new level not between held and wanted level")

endmodule

`default_nettype wire
